FILE: rtl/iee_pkg.sv
// iee_pkg: types, opcodes and character codes shared by the infix
// expression evaluator controller, datapath and top level
// depends on nothing
package iee_pkg;

  localparam int unsigned WordWidth = 32;

  typedef enum logic [1:0] {
    OP_PLUS   = 2'd0,
    OP_MINUS  = 2'd1,
    OP_TIMES  = 2'd2,
    OP_DIVIDE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DIV0    = 2'd1,
    ST_NESTING = 2'd2
  } status_t;

  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChTimes  = 8'h2A;
  localparam logic [7:0] ChDivide = 8'h2F;
  localparam logic [7:0] ChOpen   = 8'h28;
  localparam logic [7:0] ChClose  = 8'h29;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [3:0] Ten      = 4'd10;

  // datapath commands, one at a time
  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_DIGIT = 3'd1,  // accum = accum*10 + digit
    CMD_APPLY = 3'd2,  // apply pending op, optionally set new op
    CMD_PUSH  = 3'd3,  // open a level
    CMD_CLOSE = 3'd4,  // close current level
    CMD_CLEAR = 3'd5   // back to reset values
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic       set_op;
    op_t        new_op;
    logic [3:0] digit;
  } cmd_t;

  typedef struct packed {
    logic    busy;
    logic    done;      // command finished this cycle
    logic    at_top;    // level pointer is zero
    logic    stopped;
    logic    too_deep;  // push would exceed depth
    status_t err;
  } stat_t;

endpackage

FILE: rtl/iee_datapath.sv
// iee_datapath: level stack, number accumulator, iterative multiply and divide
// depends on iee_pkg
module iee_datapath #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  iee_pkg::cmd_t       cmd,
  output iee_pkg::stat_t      stat,
  output logic [31:0]         result
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = 6;

  // level stack memory (synchronous write, async read of the enclosing level)
  logic [31:0]     mem_sum  [DEPTH];
  logic [31:0]     mem_term [DEPTH];
  iee_pkg::op_t    mem_op   [DEPTH];

  logic [PtrW-1:0] ptr;
  // current level kept in registers
  logic [31:0]     cur_sum, cur_term, accum;
  iee_pkg::op_t    cur_op;
  logic            stopped;
  iee_pkg::status_t err;
  logic            done;

  // iterative unit
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_DIV  = 5'b00100,
    S_POP  = 5'b01000,
    S_FIN  = 5'b10000
  } dstate_t;
  dstate_t         ds;
  logic [CntW-1:0] cnt;
  logic [31:0]     ma, mb, prod;     // multiply shift-add
  logic [31:0]     rem, quo, dvs;   // divide restoring
  logic            qneg;
  logic            close_after;
  logic            pend_set;
  iee_pkg::op_t    pend_op;

  logic [31:0] rem_sh;
  logic [32:0] rem_try;
  assign rem_sh  = {rem[30:0], quo[31]};
  assign rem_try = {1'b0, rem_sh} - {1'b0, dvs};

  logic [31:0] abs_t, abs_n;
  assign abs_t = cur_term[31] ? (32'd0 - cur_term) : cur_term;
  assign abs_n = accum[31] ? (32'd0 - accum) : accum;

  logic [31:0] closed_v;
  assign closed_v = cur_sum + cur_term;

  logic [PtrW:0] ptr_inc;
  assign ptr_inc = {1'b0, ptr} + 1'b1;

  always_comb begin
    stat.busy     = (ds != S_IDLE);
    stat.done     = done;
    stat.at_top   = (ptr == '0);
    stat.stopped  = stopped;
    stat.too_deep = (ptr_inc >= (PtrW + 1)'(DEPTH));
    stat.err      = err;
  end
  assign result = closed_v;

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      ds <= S_IDLE; ptr <= '0; stopped <= 1'b0; err <= iee_pkg::ST_OK;
      cur_sum <= '0; cur_term <= '0; accum <= '0; cur_op <= iee_pkg::OP_PLUS;
      cnt <= '0;
    end else begin
      unique case (ds)
        S_IDLE: begin
          case (cmd.kind)
            iee_pkg::CMD_DIGIT: begin
              accum <= 32'(accum * 32'(iee_pkg::Ten)) + 32'(cmd.digit);
              done <= 1'b1;
            end
            iee_pkg::CMD_APPLY, iee_pkg::CMD_CLOSE: begin
              close_after <= (cmd.kind == iee_pkg::CMD_CLOSE);
              pend_set <= cmd.set_op;
              pend_op  <= cmd.new_op;
              case (cur_op)
                iee_pkg::OP_PLUS: begin
                  cur_sum <= closed_v; cur_term <= accum; accum <= '0;
                  ds <= S_FIN;
                end
                iee_pkg::OP_MINUS: begin
                  cur_sum <= closed_v; cur_term <= 32'd0 - accum; accum <= '0;
                  ds <= S_FIN;
                end
                iee_pkg::OP_TIMES: begin
                  ma <= cur_term; mb <= accum; prod <= '0; cnt <= '0;
                  ds <= S_MUL;
                end
                default: begin
                  if (accum == '0) begin
                    err <= iee_pkg::ST_DIV0; stopped <= 1'b1;
                    cur_term <= '0; accum <= '0; done <= 1'b1;
                  end else begin
                    quo <= abs_t; rem <= '0; dvs <= abs_n; cnt <= '0;
                    qneg <= cur_term[31] ^ accum[31];
                    ds <= S_DIV;
                  end
                end
              endcase
            end
            iee_pkg::CMD_PUSH: begin
              if (stat.too_deep) begin
                err <= iee_pkg::ST_NESTING; stopped <= 1'b1;
              end else begin
                mem_sum[ptr] <= cur_sum; mem_term[ptr] <= cur_term;
                mem_op[ptr] <= cur_op;
                ptr <= ptr_inc[PtrW-1:0];
                cur_sum <= '0; cur_term <= '0; cur_op <= iee_pkg::OP_PLUS;
                accum <= '0;
              end
              done <= 1'b1;
            end
            iee_pkg::CMD_CLEAR: begin
              ptr <= '0; stopped <= 1'b0; err <= iee_pkg::ST_OK;
              cur_sum <= '0; cur_term <= '0; accum <= '0;
              cur_op <= iee_pkg::OP_PLUS;
              done <= 1'b1;
            end
            default: ;
          endcase
        end
        // shift-add multiply, one bit a cycle
        S_MUL: begin
          if (mb[0]) prod <= prod + ma;
          ma <= {ma[30:0], 1'b0};
          mb <= {1'b0, mb[31:1]};
          cnt <= cnt + 1'b1;
          if (cnt == CntW'(31)) begin
            cur_term <= mb[0] ? prod + ma : prod;
            accum <= '0;
            ds <= S_FIN;
          end
        end
        // restoring divide, one quotient bit a cycle
        S_DIV: begin
          if (!rem_try[32]) begin
            rem <= rem_try[31:0]; quo <= {quo[30:0], 1'b1};
          end else begin
            rem <= rem_sh; quo <= {quo[30:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == CntW'(31)) begin
            cur_term <= qneg ? 32'd0 - {quo[30:0], ~rem_try[32]}
                             : {quo[30:0], ~rem_try[32]};
            accum <= '0;
            ds <= S_FIN;
          end
        end
        // finish apply: set op or close the level
        S_FIN: begin
          if (pend_set) cur_op <= pend_op;
          if (close_after) begin
            if (ptr != '0) begin
              accum <= closed_v;
              ds <= S_POP;
            end else begin
              cur_sum <= closed_v; cur_term <= '0; cur_op <= iee_pkg::OP_PLUS;
              stopped <= 1'b1;
              done <= 1'b1;
              ds <= S_IDLE;
            end
          end else begin
            done <= 1'b1;
            ds <= S_IDLE;
          end
        end
        // restore the enclosing level
        S_POP: begin
          ptr <= ptr - 1'b1;
          cur_sum <= mem_sum[ptr - 1'b1];
          cur_term <= mem_term[ptr - 1'b1];
          cur_op <= mem_op[ptr - 1'b1];
          done <= 1'b1;
          ds <= S_IDLE;
        end
        default: ds <= S_IDLE;
      endcase
    end
  end

  // error always comes with stop
  assert property (@(posedge clk) disable iff (rst)
    (err != iee_pkg::ST_OK) |-> stopped) else $error("error without stop");
  // multiply only starts from idle with a pending times op
  assert property (@(posedge clk) disable iff (rst)
    (ds == S_MUL) && $past(ds == S_IDLE) |-> $past(cur_op == iee_pkg::OP_TIMES))
    else $error("multiply started without times");
  // pop only below top level
  assert property (@(posedge clk) disable iff (rst)
    (ds == S_POP) |-> (ptr != '0)) else $error("pop at top level");

endmodule

FILE: rtl/iee_control.sv
// iee_control: per-character sequencer issuing datapath commands
// depends on iee_pkg
module iee_control (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           ch,
  input  logic                 last,
  output iee_pkg::cmd_t        cmd,
  input  iee_pkg::stat_t       stat,
  input  logic [31:0]          result,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [31:0]          out_value,
  output logic [1:0]           out_status
);

  typedef enum logic [5:0] {
    C_IDLE  = 6'b000001,
    C_CHAR  = 6'b000010,
    C_WAIT  = 6'b000100,
    C_CLOSE = 6'b001000,
    C_CWAIT = 6'b010000,
    C_CLEAR = 6'b100000
  } cstate_t;

  cstate_t    cs;
  logic [7:0] ch_r;
  logic       last_r;

  logic is_digit;
  assign is_digit = (ch_r >= iee_pkg::ChZero) && (ch_r <= iee_pkg::ChNine);

  assign in_ready = (cs == C_IDLE) && !out_valid;

  // command decode
  always_comb begin
    cmd = '{kind: iee_pkg::CMD_NONE, set_op: 1'b0, new_op: iee_pkg::OP_PLUS,
            digit: 4'(ch_r - iee_pkg::ChZero)};
    unique case (cs)
      C_CHAR: begin
        if (!stat.stopped) begin
          if (is_digit) cmd.kind = iee_pkg::CMD_DIGIT;
          else case (ch_r)
            iee_pkg::ChPlus:   begin cmd.kind = iee_pkg::CMD_APPLY; cmd.set_op = 1'b1;
                                 cmd.new_op = iee_pkg::OP_PLUS; end
            iee_pkg::ChMinus:  begin cmd.kind = iee_pkg::CMD_APPLY; cmd.set_op = 1'b1;
                                 cmd.new_op = iee_pkg::OP_MINUS; end
            iee_pkg::ChTimes:  begin cmd.kind = iee_pkg::CMD_APPLY; cmd.set_op = 1'b1;
                                 cmd.new_op = iee_pkg::OP_TIMES; end
            iee_pkg::ChDivide: begin cmd.kind = iee_pkg::CMD_APPLY; cmd.set_op = 1'b1;
                                 cmd.new_op = iee_pkg::OP_DIVIDE; end
            iee_pkg::ChOpen:   cmd.kind = iee_pkg::CMD_PUSH;
            iee_pkg::ChClose:  cmd.kind = iee_pkg::CMD_CLOSE;
            default: ;
          endcase
        end
      end
      C_CLOSE: if (!stat.stopped) cmd.kind = iee_pkg::CMD_CLOSE;
      C_CLEAR: cmd.kind = iee_pkg::CMD_CLEAR;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cs <= C_IDLE; out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (cs)
        C_IDLE: if (in_valid && in_ready) begin
          ch_r <= ch; last_r <= last; cs <= C_CHAR;
        end
        C_CHAR: begin
          if (cmd.kind == iee_pkg::CMD_NONE) cs <= last_r ? C_CLOSE : C_IDLE;
          else if (cmd.kind == iee_pkg::CMD_DIGIT || cmd.kind == iee_pkg::CMD_PUSH)
            cs <= last_r ? C_CLOSE : C_IDLE;
          else cs <= C_WAIT;
        end
        C_WAIT: if (stat.done) cs <= last_r ? C_CLOSE : C_IDLE;
        C_CLOSE: begin
          if (stat.stopped) begin
            out_value  <= (stat.err == iee_pkg::ST_OK) ? result : '0;
            out_status <= stat.err;
            out_valid  <= 1'b1;
            cs <= C_CLEAR;
          end else cs <= C_CWAIT;
        end
        C_CWAIT: if (stat.done) cs <= C_CLOSE;
        C_CLEAR: cs <= C_IDLE;
        default: cs <= C_IDLE;
      endcase
    end
  end

  // no new request while a result waits
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> !(in_valid && in_ready) || !$past(out_valid))
    else $error("request taken with result pending");
  // result only raised from closing
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cs == C_CLOSE)) else $error("stray result");
  // clear always follows a result
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (cs == C_CLEAR)) else $error("no clear after result");

endmodule

FILE: rtl/infix_expression_evaluator.sv
// infix_expression_evaluator: top level, joins the sequencer and the datapath
// depends on iee_pkg, iee_control, iee_datapath
//
// Takes an expression one character per request (tlast marks the final one)
// and gives one signed 32-bit value with a status code after the last
// character. A digit, space, '(' or ignored character needs no apply; an
// operator applies the pending one, and when that is * or / the multiply or
// divide runs one bit a cycle in an iterative shift unit; a division by zero
// stops without running the divider. A ')' costs the same as an operator at
// the top level and adds a pop below it. After the last character each still
// open level, up to DEPTH-1 of them, costs one more apply plus a pop, the top
// level a final apply, then the result is raised and the clear state follows.
module infix_expression_evaluator #(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // char_code
  input  logic        s_axis_tlast,   // last_char
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // value[31:0], status[33:32], zero fill
);

  iee_pkg::cmd_t  cmd;
  iee_pkg::stat_t stat;
  logic [31:0]    result, out_value;
  logic [1:0]     out_status;

  iee_control u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .ch(s_axis_tdata), .last(s_axis_tlast),
    .cmd(cmd), .stat(stat), .result(result),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_value(out_value), .out_status(out_status)
  );

  iee_datapath #(.DEPTH(DEPTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .result(result)
  );

  assign m_axis_tdata = {6'd0, out_status, out_value};

endmodule

FILE: dv/tb_infix_expression_evaluator.sv
// tb_infix_expression_evaluator: self-checking bench for the infix expression evaluator
// drives character streams, predicts value and status per expression, checks results
// depends on iee_pkg and infix_expression_evaluator
`timescale 1ns / 100ps

module tb_infix_expression_evaluator;

  localparam int unsigned Depth = 16;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_req_t;

  typedef struct packed {
    logic [31:0]      value;
    iee_pkg::status_t status;
  } eval_result_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;

  infix_expression_evaluator #(.DEPTH(Depth)) i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  // clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // evaluator mirror state
  logic [31:0]      lv_sum [Depth];
  logic [31:0]      lv_term[Depth];
  iee_pkg::op_t     lv_op  [Depth];
  logic [31:0]      num_acc;
  int unsigned      lv_ptr;
  bit               halted;
  iee_pkg::status_t err_code;

  char_req_t    pending_chars[$];
  eval_result_t expected_results[$];
  int unsigned  n_mismatch;
  int unsigned  n_checked;
  int unsigned  n_chars;
  bit           stim_done;

  function automatic void clear_eval();
    for (int k = 0; k < Depth; k++) begin
      lv_sum[k] = '0;
      lv_term[k] = '0;
      lv_op[k] = iee_pkg::OP_PLUS;
    end
    num_acc = '0;
    lv_ptr = 0;
    halted = 1'b0;
    err_code = iee_pkg::ST_OK;
  endfunction

  function automatic logic [31:0] quot_trunc(logic [31:0] a, logic [31:0] b);
    logic [31:0] ua;
    logic [31:0] ub;
    logic [31:0] q;
    ua = a[31] ? -a : a;
    ub = b[31] ? -b : b;
    q = ua / ub;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  // fold the pending number into the current level
  function automatic void fold_number();
    int unsigned k;
    k = (lv_ptr < Depth) ? lv_ptr : Depth - 1;
    case (lv_op[k])
      iee_pkg::OP_PLUS: begin
        lv_sum[k] += lv_term[k];
        lv_term[k] = num_acc;
      end
      iee_pkg::OP_MINUS: begin
        lv_sum[k] += lv_term[k];
        lv_term[k] = -num_acc;
      end
      iee_pkg::OP_TIMES: lv_term[k] = lv_term[k] * num_acc;
      default: begin
        if (num_acc == 0) begin
          err_code = iee_pkg::ST_DIV0;
          halted = 1'b1;
          lv_term[k] = '0;
        end else begin
          lv_term[k] = quot_trunc(lv_term[k], num_acc);
        end
      end
    endcase
    num_acc = '0;
  endfunction

  function automatic void pop_level();
    int unsigned k;
    logic [31:0] v;
    fold_number();
    if (err_code != iee_pkg::ST_OK) return;
    k = (lv_ptr < Depth) ? lv_ptr : Depth - 1;
    v = lv_sum[k] + lv_term[k];
    if (k > 0) begin
      lv_ptr = k - 1;
      num_acc = v;
    end else begin
      lv_sum[0] = v;
      lv_term[0] = '0;
      lv_op[0] = iee_pkg::OP_PLUS;
      halted = 1'b1;
    end
  endfunction

  // advance the mirror by one accepted character
  function automatic void eval_char(char_req_t r);
    int unsigned k;
    eval_result_t res;
    k = (lv_ptr < Depth) ? lv_ptr : Depth - 1;
    if (!halted) begin
      if (r.ch >= iee_pkg::ChZero && r.ch <= iee_pkg::ChNine) begin
        num_acc = num_acc * 10 + (r.ch - iee_pkg::ChZero);
      end else if (r.ch == iee_pkg::ChPlus || r.ch == iee_pkg::ChMinus ||
                   r.ch == iee_pkg::ChTimes || r.ch == iee_pkg::ChDivide) begin
        fold_number();
        if (err_code == iee_pkg::ST_OK)
          lv_op[k] = (r.ch == iee_pkg::ChPlus) ? iee_pkg::OP_PLUS :
                     (r.ch == iee_pkg::ChMinus) ? iee_pkg::OP_MINUS :
                     (r.ch == iee_pkg::ChTimes) ? iee_pkg::OP_TIMES : iee_pkg::OP_DIVIDE;
      end else if (r.ch == iee_pkg::ChOpen) begin
        if (k + 1 >= Depth) begin
          err_code = iee_pkg::ST_NESTING;
          halted = 1'b1;
        end else begin
          lv_ptr = k + 1;
          lv_sum[k+1] = '0;
          lv_term[k+1] = '0;
          lv_op[k+1] = iee_pkg::OP_PLUS;
          num_acc = '0;
        end
      end else if (r.ch == iee_pkg::ChClose) begin
        pop_level();
      end
    end
    if (r.last) begin
      while (!halted) pop_level();
      res.value = (err_code == iee_pkg::ST_OK) ? lv_sum[0] + lv_term[0] : '0;
      res.status = err_code;
      expected_results = {expected_results, res};
      clear_eval();
    end
  endfunction

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // stimulus builders
  task automatic add_text(string s);
    char_req_t r;
    for (int i = 0; i < s.len(); i++) begin
      r.ch = s[i];
      r.last = (i == s.len() - 1);
      pending_chars = {pending_chars, r};
    end
  endtask

  function automatic string rand_number();
    string s;
    int unsigned n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 11) : $urandom_range(1, 3);
    s = "";
    for (int i = 0; i < n; i++)
      s = {s, string'(8'(iee_pkg::ChZero + $urandom_range(0, 9)))};
    return s;
  endfunction

  function automatic string rand_expr(int unsigned lvl);
    string s;
    string ops;
    int unsigned terms;
    ops = "+-*/";
    terms = $urandom_range(1, 4);
    s = ($urandom_range(0, 7) == 0) ? "-" : "";
    for (int t = 0; t < terms; t++) begin
      if (t > 0) begin
        s = {s, string'(ops[$urandom_range(0, 3)])};
        if ($urandom_range(0, 3) == 0) s = {s, " "};
      end
      if (lvl < 5 && $urandom_range(0, 3) == 0) s = {s, "(", rand_expr(lvl + 1), ")"};
      else s = {s, rand_number()};
    end
    return s;
  endfunction

  function automatic string rand_noise();
    string s;
    int unsigned n;
    n = $urandom_range(1, 12);
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(0, 255)))};
    return s;
  endfunction

  // fill the request queue
  initial begin
    string e;
    stim_done = 1'b0;
    add_text("0");
    add_text("2147483647+1");
    add_text("-2147483648/-1");
    add_text("4294967295");
    add_text("7 - 10 / 3 * 2");
    add_text("-7/2");
    add_text("(1+2)*(3-4)");
    add_text("5/0+1");
    add_text("((((((((((((((((1))))))))))))))))");
    add_text("(((((((((((((((2+3");
    add_text("3)+99");
    add_text("2(5)");
    add_text("(4)12");
    add_text("a1b#2\377");
    add_text(" ");
    add_text("6*-2");
    while (pending_chars.size() < 1400) begin
      case ($urandom_range(0, 9))
        0: e = rand_noise();
        1: e = {rand_expr(0), ")", rand_noise()};
        2: e = {"(((((((((((((((", rand_expr(0)};
        default: e = rand_expr(0);
      endcase
      add_text(e);
    end
    stim_done = 1'b1;
  end

  // reset and input defaults
  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    m_axis_tready = 1'b0;
    clear_eval();
    n_mismatch = 0;
    n_checked = 0;
    n_chars = 0;
    repeat (10) @(posedge clk);
    @(negedge clk) rst = 1'b0;
  end

  // remember whether the request was taken at the last rising edge
  logic req_taken;
  always @(posedge clk) req_taken <= s_axis_tvalid && s_axis_tready;

  // request driver, changes on the falling edge
  int unsigned src_gap;
  initial src_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && !req_taken) begin
        // hold the current request
      end else if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_chars.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pending_chars[0].ch;
        s_axis_tlast <= pending_chars[0].last;
        void'(pending_chars.pop_front());
        src_gap <= gap_len();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result backpressure
  int unsigned sink_gap;
  initial sink_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (sink_gap > 0) begin
        sink_gap <= sink_gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) sink_gap <= gap_len();
      end
    end
  end

  // monitor: predict on accepted requests, check accepted results
  always @(posedge clk) begin
    char_req_t r;
    eval_result_t want;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        r.ch = s_axis_tdata;
        r.last = s_axis_tlast;
        eval_char(r);
        n_chars++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("unexpected result value=%0d status=%0d",
                     $signed(m_axis_tdata[31:0]), m_axis_tdata[33:32]);
        end else begin
          want = expected_results.pop_front();
          n_checked++;
          if (m_axis_tdata[31:0] !== want.value || m_axis_tdata[33:32] !== want.status) begin
            n_mismatch++;
            if (n_mismatch <= 10)
              $display("result %0d mismatch: expected value=%0d status=%0d, got value=%0d status=%0d",
                       n_checked, $signed(want.value), want.status,
                       $signed(m_axis_tdata[31:0]), m_axis_tdata[33:32]);
          end
        end
      end
    end
  end

  // end of run
  initial begin
    wait (stim_done);
    @(posedge clk);
    while (pending_chars.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
    $display("%0d characters sent, %0d expressions checked, %0d mismatches",
             n_chars, n_checked, n_mismatch);
    if (n_mismatch == 0 && expected_results.size() == 0)
      $display("infix_expression_evaluator regression: pass");
    else
      $display("infix_expression_evaluator regression: fail");
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("timeout waiting for results");
    $display("infix_expression_evaluator regression: fail");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/iee_pkg.sv
rtl/iee_datapath.sv
rtl/iee_control.sv
rtl/infix_expression_evaluator.sv
dv/tb_infix_expression_evaluator.sv
